// ----- src/tqla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqla_pkg
// Shared types and constants of the tabular Q-learning agent.
// ----------------------------------------------------------------------------
package tqla_pkg;

  localparam int Q_W         = 32;     // Q16.16 table value
  localparam int FRAC_W      = 17;     // Q1.16 fraction register, one included
  localparam int STATE_W     = 8;
  localparam int NUM_ACTIONS = 4;
  localparam int ACTION_W    = 2;
  localparam int MAX_ROWS    = 256;    // rows addressable by an 8-bit state
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  typedef logic [NUM_ACTIONS-1:0][Q_W-1:0] row_t;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CHOOSE = 2'd2,
    CMD_LEARN  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_LEARN_RATE  = 2'd0,
    CFG_DISCOUNT    = 2'd1,
    CFG_START_STATE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCESS,
    S_L_MAX,
    S_L_Q,
    S_L_DIFF,
    S_L_PROD,
    S_L_WRITE
  } state_e;

  // One row read every cycle, one row written on request.
  typedef struct packed {
    logic [STATE_W-1:0] rd_state;
    logic               wr_en;
    logic [STATE_W-1:0] wr_state;
    row_t               wr_row;
  } mem_req_t;

  // Load strobes for the update datapath.
  typedef struct packed {
    logic ld_max;
    logic ld_q;
    logic ld_diff;
    logic ld_prod;
  } alu_ctrl_t;

endpackage

// ----- src/tqla_qmem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqla_qmem
// Q-table storage: one row of four values per state, registered synchronous
// read, per-row valid bits so that unwritten rows read zero.
// ----------------------------------------------------------------------------
module tqla_qmem #(
  parameter int NUM_STATES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tqla_pkg::mem_req_t req_i,
  output tqla_pkg::row_t     rdata_o
);
  import tqla_pkg::*;

  localparam int ROWS   = (NUM_STATES < MAX_ROWS) ? NUM_STATES : MAX_ROWS;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [STATE_W:0] ROWS_L = (STATE_W + 1)'(ROWS);

  row_t              mem [ROWS];
  logic [ROWS-1:0]   valid_q;
  row_t              rdata_q;
  logic              rd_ok_q;
  logic              rd_held;
  logic              wr_held;
  logic [ROW_AW-1:0] rd_row;
  logic [ROW_AW-1:0] wr_row_idx;

  // States past the table end read as zero and drop their writes.
  assign rd_held    = {1'b0, req_i.rd_state} < ROWS_L;
  assign wr_held    = {1'b0, req_i.wr_state} < ROWS_L;
  assign rd_row     = req_i.rd_state[ROW_AW-1:0];
  assign wr_row_idx = req_i.wr_state[ROW_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && wr_held) begin
      mem[wr_row_idx] <= req_i.wr_row;
    end
    rdata_q <= mem[rd_row];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (req_i.wr_en && wr_held) begin
        valid_q[wr_row_idx] <= 1'b1;
      end
      rd_ok_q <= rd_held && valid_q[rd_row];
    end
  end

  assign rdata_o = rd_ok_q ? rdata_q : '0;

endmodule

// ----- src/tqla_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqla_alu
// Greedy selection over a row and the registered Q-update datapath:
// row max, discount product, difference, learning-rate product, saturating sum.
// ----------------------------------------------------------------------------
module tqla_alu (
  input  logic                          clk_i,
  input  tqla_pkg::alu_ctrl_t           ctrl_i,
  input  tqla_pkg::row_t                row_i,
  input  logic [tqla_pkg::ACTION_W-1:0] action_i,
  input  logic signed [tqla_pkg::Q_W-1:0] reward_i,
  input  logic [tqla_pkg::FRAC_W-1:0]   learn_rate_i,
  input  logic [tqla_pkg::FRAC_W-1:0]   discount_i,
  output logic [tqla_pkg::ACTION_W-1:0] greedy_o,
  output logic signed [tqla_pkg::Q_W-1:0] new_q_o
);
  import tqla_pkg::*;

  localparam int P1_W   = Q_W + FRAC_W + 1;   // value times unsigned fraction
  localparam int DIFF_W = Q_W + 3;
  localparam int P2_W   = DIFF_W + FRAC_W + 1;
  localparam int SUM_W  = P2_W - 16;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(64'sh8000_0000);

  logic signed [Q_W-1:0]    max_q;
  logic signed [Q_W-1:0]    q_q;
  logic signed [P1_W-1:0]   p1_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [P2_W-1:0]   p2_q;
  logic signed [Q_W-1:0]    row_max;
  logic signed [SUM_W-1:0]  addend;
  logic signed [SUM_W-1:0]  sum;
  logic                     carry_in;

  // Strict compare keeps the lowest index on ties.
  always_comb begin
    greedy_o = '0;
    row_max  = $signed(row_i[0]);
    for (int i = 1; i < NUM_ACTIONS; i++) begin
      if (row_max < $signed(row_i[i])) begin
        row_max  = $signed(row_i[i]);
        greedy_o = ACTION_W'(i);
      end
    end
  end

  // Rounding to nearest with ties up: floor(p / 2^16) plus bit 15 of p.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_max) begin
      max_q <= row_max;
    end
    if (ctrl_i.ld_q) begin
      q_q  <= $signed(row_i[action_i]);
      p1_q <= max_q * $signed({1'b0, discount_i});
    end
    if (ctrl_i.ld_diff) begin
      diff_q <= DIFF_W'(p1_q >>> 16) - DIFF_W'(q_q) + {{(DIFF_W-1){1'b0}}, p1_q[15]};
    end
    if (ctrl_i.ld_prod) begin
      p2_q <= diff_q * $signed({1'b0, learn_rate_i});
    end
  end

  // A nonzero reward is added as is; otherwise the rounded update is added.
  always_comb begin
    if (reward_i != '0) begin
      addend   = SUM_W'(reward_i);
      carry_in = 1'b0;
    end else begin
      addend   = SUM_W'(p2_q >>> 16);
      carry_in = p2_q[15];
    end
    sum = SUM_W'(q_q) + addend + {{(SUM_W-1){1'b0}}, carry_in};
    priority if (sum > SAT_HI) begin
      new_q_o = SAT_HI[Q_W-1:0];
    end else if (sum < SAT_LO) begin
      new_q_o = SAT_LO[Q_W-1:0];
    end else begin
      new_q_o = sum[Q_W-1:0];
    end
  end

endmodule

// ----- src/tabular_q_learning_agent_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabular_q_learning_agent_top
// Tabular Q-learning agent with greedy action choice, Q16.16 values.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. Its result word
// is on the outputs for exactly one cycle, flagged by done_o, and must be
// taken then. Write, read and choose commands hold busy_o in S_ACCESS and
// deliver their word in the following cycle; a learn command holds busy_o
// from S_L_MAX through S_L_WRITE (two row reads through the single read
// port of the table, then two multiplies and a saturating add in a
// registered chain) and delivers its word after them. A new command may be
// issued in the cycle that carries the previous result; none is taken while
// one is in flight. Per-row valid bits clear the table at reset, with no
// clearing pass. Configuration must be written only while no command is in
// flight (unenforced by the block); writing start_state moves the agent there.
// ----------------------------------------------------------------------------
module tabular_q_learning_agent_top #(
  parameter int NUM_STATES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  output logic                           done_o,
  input  logic [1:0]                     cmd_i,
  input  logic [tqla_pkg::STATE_W-1:0]   entry_state_i,
  input  logic [tqla_pkg::ACTION_W-1:0]  entry_action_i,
  input  logic signed [tqla_pkg::Q_W-1:0] entry_value_i,
  input  logic signed [tqla_pkg::Q_W-1:0] reward_i,
  input  logic [tqla_pkg::STATE_W-1:0]   next_state_i,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [tqla_pkg::FRAC_W-1:0]    cfg_wdata_i,
  output logic [tqla_pkg::ACTION_W-1:0]  chosen_action_o,
  output logic signed [tqla_pkg::Q_W-1:0] read_value_o,
  output logic [tqla_pkg::STATE_W-1:0]   agent_state_o
);
  import tqla_pkg::*;

  state_e              state_q, state_d;
  cmd_e                cmd_in;
  cmd_e                cmd_q;
  logic [STATE_W-1:0]  es_q;
  logic [ACTION_W-1:0] ea_q;
  logic [Q_W-1:0]      ev_q;
  logic signed [Q_W-1:0] rw_q;
  logic [STATE_W-1:0]  ns_q;
  row_t                row_q;
  logic                row_ld;

  logic [STATE_W-1:0]  cur_q;
  logic                cur_upd;
  logic [ACTION_W-1:0] la_q, la_d;
  logic [FRAC_W-1:0]   lr_q;
  logic [FRAC_W-1:0]   disc_q;
  logic [FRAC_W-1:0]   cfg_frac;

  logic                done_q, done_d;
  logic [ACTION_W-1:0] act_q, act_d;
  logic signed [Q_W-1:0] val_q, val_d;

  logic                accept;
  mem_req_t            req;
  row_t                rdata;
  alu_ctrl_t           alu_ctrl;
  logic [ACTION_W-1:0] greedy;
  logic signed [Q_W-1:0] new_q;

  assign cmd_in   = cmd_e'(cmd_i);
  assign accept   = start_i && (state_q == S_IDLE);
  assign cfg_frac = (cfg_wdata_i > FRAC_ONE) ? FRAC_ONE : cfg_wdata_i;

  tqla_qmem #(
    .NUM_STATES(NUM_STATES)
  ) u_qmem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rdata_o(rdata)
  );

  tqla_alu u_alu (
    .clk_i       (clk_i),
    .ctrl_i      (alu_ctrl),
    .row_i       (rdata),
    .action_i    (la_q),
    .reward_i    (rw_q),
    .learn_rate_i(lr_q),
    .discount_i  (disc_q),
    .greedy_o    (greedy),
    .new_q_o     (new_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cur_q   <= '0;
      la_q    <= '0;
      lr_q    <= 17'd6554;
      disc_q  <= 17'd58982;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      la_q    <= la_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LEARN_RATE:  lr_q   <= cfg_frac;
          CFG_DISCOUNT:    disc_q <= cfg_frac;
          CFG_START_STATE: cur_q  <= cfg_wdata_i[STATE_W-1:0];
          default: ;
        endcase
      end else if (cur_upd) begin
        cur_q <= ns_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_in;
      es_q  <= entry_state_i;
      ea_q  <= entry_action_i;
      ev_q  <= entry_value_i;
      rw_q  <= reward_i;
      ns_q  <= next_state_i;
    end
    if (row_ld) begin
      row_q <= rdata;
    end
    act_q <= act_d;
    val_q <= val_d;
  end

  always_comb begin
    state_d      = state_q;
    req          = '0;
    req.rd_state = cur_q;
    alu_ctrl     = '0;
    row_ld       = 1'b0;
    cur_upd      = 1'b0;
    la_d         = la_q;
    done_d       = 1'b0;
    act_d        = '0;
    val_d        = '0;
    unique case (state_q)
      S_IDLE: begin
        // A learn reads the next-state row first, then the current row.
        unique case (cmd_in)
          CMD_LEARN:          req.rd_state = next_state_i;
          CMD_CHOOSE:         req.rd_state = cur_q;
          CMD_WRITE, CMD_READ: req.rd_state = entry_state_i;
        endcase
        if (accept) begin
          state_d = (cmd_in == CMD_LEARN) ? S_L_MAX : S_ACCESS;
        end
      end
      S_ACCESS: begin
        unique case (cmd_q)
          CMD_WRITE: begin
            req.wr_en          = 1'b1;
            req.wr_state       = es_q;
            req.wr_row         = rdata;
            req.wr_row[ea_q]   = ev_q;
          end
          CMD_READ: begin
            val_d = $signed(rdata[ea_q]);
          end
          CMD_CHOOSE: begin
            la_d  = greedy;
            act_d = greedy;
          end
          CMD_LEARN: ;
        endcase
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      S_L_MAX: begin
        alu_ctrl.ld_max = 1'b1;
        req.rd_state    = cur_q;
        state_d         = S_L_Q;
      end
      S_L_Q: begin
        alu_ctrl.ld_q = 1'b1;
        row_ld        = 1'b1;
        state_d       = S_L_DIFF;
      end
      S_L_DIFF: begin
        alu_ctrl.ld_diff = 1'b1;
        state_d          = S_L_PROD;
      end
      S_L_PROD: begin
        alu_ctrl.ld_prod = 1'b1;
        state_d          = S_L_WRITE;
      end
      S_L_WRITE: begin
        req.wr_en        = 1'b1;
        req.wr_state     = cur_q;
        req.wr_row       = row_q;
        req.wr_row[la_q] = new_q;
        val_d            = new_q;
        cur_upd          = 1'b1;
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign chosen_action_o = act_q;
  assign read_value_o    = val_q;
  assign agent_state_o   = cur_q;

endmodule
